>>> sv/gpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_pkg
// Widths, limb splits, saturation limits and sideband types shared by the
// gravity pair force pipeline.
// ----------------------------------------------------------------------------
package gpf_pkg;

    localparam int POS_W      = 48;
    localparam int MASS_W     = 40;
    localparam int DIF_W      = POS_W + 1;
    localparam int MAG_W      = POS_W + 1;
    localparam int N_ACC      = 4;

    localparam int IN_W       = 4 * POS_W + 2 * MASS_W;
    localparam int ACC_W      = 48;
    localparam int POT_W      = 64;
    localparam int OUT_W      = N_ACC * ACC_W + POT_W;

    // limb splits for the front multipliers
    localparam int DLO_W      = 25;
    localparam int DHI_W      = MAG_W - DLO_W;
    localparam int MLO_W      = 20;
    localparam int MHI_W      = MASS_W - MLO_W;
    localparam int SQ_W       = 2 * DLO_W;
    localparam int PP_W       = MLO_W + DLO_W;
    localparam int MMP_W      = 2 * MLO_W;

    localparam int S_W        = 2 * MAG_W;
    localparam int P_W        = MASS_W + MAG_W;
    localparam int MM_W       = 2 * MASS_W;

    // root of S * 2^32
    localparam int SQ_SHIFT   = 32;
    localparam int X_W        = S_W + SQ_SHIFT;
    localparam int T_W        = X_W + 1;
    localparam int ROOT_W     = 66;
    localparam int SQRT_STEPS = ROOT_W;

    // S * R
    localparam int SLIMB_W    = 25;
    localparam int N_SLIMB    = 4;
    localparam int RLIMB_W    = 22;
    localparam int N_RLIMB    = 3;
    localparam int SPAD_W     = SLIMB_W * N_SLIMB;
    localparam int LPP_W      = SLIMB_W + RLIMB_W;
    localparam int LSUM_W     = SPAD_W + RLIMB_W;
    localparam int DEN_W      = S_W + ROOT_W;

    // dividers
    localparam int ACC_SHIFT  = 92 - ACC_W;
    localparam int ACC_STEPS  = ACC_W;
    localparam int POT_SHIFT  = 32;
    localparam int POT_STEPS  = POT_W;

    localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [N_ACC-1:0] neg;
        logic             zero;
    } t_flags;

    typedef struct packed {
        logic [N_ACC-1:0][P_W-1:0] prod;
        logic [MM_W-1:0]           mm;
        t_flags                    flags;
    } t_side;

    typedef struct packed {
        logic [N_ACC-1:0][ACC_W-1:0] q_acc;
        logic [N_ACC-1:0]            ovf_acc;
        logic [POT_W-1:0]            q_pot;
        logic                        ovf_pot;
        t_flags                      flags;
    } t_res;

endpackage

>>> sv/gpf_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_prep
// Separation, magnitudes and signs, then limb products and their sums:
// S = dx^2 + dy^2, mass times distance terms and ma*mb. Three stages.
// ----------------------------------------------------------------------------
module gpf_prep
    import gpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [POS_W-1:0]  i_pos_a_x,
    input  logic signed [POS_W-1:0]  i_pos_a_y,
    input  logic signed [POS_W-1:0]  i_pos_b_x,
    input  logic signed [POS_W-1:0]  i_pos_b_y,
    input  logic [MASS_W-1:0]        i_mass_a,
    input  logic [MASS_W-1:0]        i_mass_b,
    output logic [S_W-1:0]           o_s,
    output t_side                    o_side,
    output logic                     o_vld
);

    logic signed [DIF_W-1:0] dx, dy;
    logic [MAG_W-1:0]        n1_mag [2];
    t_flags                  n1_flags;

    logic [MAG_W-1:0]        r1_mag [2];
    logic [MASS_W-1:0]       r1_ma, r1_mb;
    t_flags                  r1_flags;
    logic                    r1_vld;

    logic [SQ_W-1:0]         n2_sq  [2][3];
    logic [PP_W-1:0]         n2_pp  [N_ACC][4];
    logic [MMP_W-1:0]        n2_mm  [4];
    logic [SQ_W-1:0]         r2_sq  [2][3];
    logic [PP_W-1:0]         r2_pp  [N_ACC][4];
    logic [MMP_W-1:0]        r2_mm  [4];
    t_flags                  r2_flags;
    logic                    r2_vld;

    logic [S_W-1:0]          n3_s;
    t_side                   n3_side;
    logic [S_W-1:0]          r3_s;
    t_side                   r3_side;
    logic                    r3_vld;

    assign dx = DIF_W'(i_pos_b_x) - DIF_W'(i_pos_a_x);
    assign dy = DIF_W'(i_pos_b_y) - DIF_W'(i_pos_a_y);

    always_comb begin
        n1_mag[0]     = dx[DIF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        n1_mag[1]     = dy[DIF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        n1_flags.neg  = {!dy[DIF_W-1] && (dy != '0), !dx[DIF_W-1] && (dx != '0),
                         dy[DIF_W-1], dx[DIF_W-1]};
        n1_flags.zero = (dx == '0) && (dy == '0);
    end

    always_comb begin
        logic [MASS_W-1:0] m;
        logic [MAG_W-1:0]  d;
        for (int j = 0; j < 2; j++) begin
            n2_sq[j][0] = SQ_W'(r1_mag[j][DLO_W-1:0]) * SQ_W'(r1_mag[j][DLO_W-1:0]);
            n2_sq[j][1] = SQ_W'(r1_mag[j][DLO_W-1:0]) * SQ_W'(r1_mag[j][MAG_W-1:DLO_W]);
            n2_sq[j][2] = SQ_W'(r1_mag[j][MAG_W-1:DLO_W]) * SQ_W'(r1_mag[j][MAG_W-1:DLO_W]);
        end
        for (int k = 0; k < N_ACC; k++) begin
            m = (k < 2) ? r1_mb : r1_ma;
            d = r1_mag[k % 2];
            n2_pp[k][0] = PP_W'(m[MLO_W-1:0]) * PP_W'(d[DLO_W-1:0]);
            n2_pp[k][1] = PP_W'(m[MLO_W-1:0]) * PP_W'(d[MAG_W-1:DLO_W]);
            n2_pp[k][2] = PP_W'(m[MASS_W-1:MLO_W]) * PP_W'(d[DLO_W-1:0]);
            n2_pp[k][3] = PP_W'(m[MASS_W-1:MLO_W]) * PP_W'(d[MAG_W-1:DLO_W]);
        end
        n2_mm[0] = MMP_W'(r1_ma[MLO_W-1:0]) * MMP_W'(r1_mb[MLO_W-1:0]);
        n2_mm[1] = MMP_W'(r1_ma[MLO_W-1:0]) * MMP_W'(r1_mb[MASS_W-1:MLO_W]);
        n2_mm[2] = MMP_W'(r1_ma[MASS_W-1:MLO_W]) * MMP_W'(r1_mb[MLO_W-1:0]);
        n2_mm[3] = MMP_W'(r1_ma[MASS_W-1:MLO_W]) * MMP_W'(r1_mb[MASS_W-1:MLO_W]);
    end

    always_comb begin
        n3_s = '0;
        for (int j = 0; j < 2; j++) begin
            n3_s = n3_s + S_W'(r2_sq[j][0]) + (S_W'(r2_sq[j][1]) << (DLO_W + 1))
                 + (S_W'(r2_sq[j][2]) << (2 * DLO_W));
        end
        for (int k = 0; k < N_ACC; k++) begin
            n3_side.prod[k] = P_W'(r2_pp[k][0]) + (P_W'(r2_pp[k][1]) << DLO_W)
                            + (P_W'(r2_pp[k][2]) << MLO_W)
                            + (P_W'(r2_pp[k][3]) << (MLO_W + DLO_W));
        end
        n3_side.mm    = MM_W'(r2_mm[0]) + (MM_W'(r2_mm[1]) << MLO_W)
                      + (MM_W'(r2_mm[2]) << MLO_W) + (MM_W'(r2_mm[3]) << (2 * MLO_W));
        n3_side.flags = r2_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag   <= n1_mag;
            r1_ma    <= i_mass_a;
            r1_mb    <= i_mass_b;
            r1_flags <= n1_flags;
            r2_sq    <= n2_sq;
            r2_pp    <= n2_pp;
            r2_mm    <= n2_mm;
            r2_flags <= r1_flags;
            r3_s     <= n3_s;
            r3_side  <= n3_side;
        end
    end

    assign o_s    = r3_s;
    assign o_side = r3_side;
    assign o_vld  = r3_vld;

endmodule

>>> sv/gpf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_sqrt
// Digit-by-digit floor square root of S * 2^32, one root bit per stage,
// most significant bit first.
// ----------------------------------------------------------------------------
module gpf_sqrt
    import gpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [S_W-1:0]    i_s,
    input  t_side             i_side,
    output logic [S_W-1:0]    o_s,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side,
    output logic              o_vld
);

    logic [X_W-1:0]    r_rm   [1:SQRT_STEPS];
    logic [ROOT_W-1:0] r_root [1:SQRT_STEPS];
    logic [S_W-1:0]    r_s    [1:SQRT_STEPS];
    t_side             r_side [1:SQRT_STEPS];
    logic              r_vld  [1:SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam int B = SQRT_STEPS - 1 - k;

        logic [X_W-1:0]    rm_in;
        logic [ROOT_W-1:0] root_in;
        logic [S_W-1:0]    s_in;
        t_side             side_in;
        logic              vld_in;
        logic [T_W-1:0]    rem_ext, trial;
        logic              ge;
        logic [X_W-1:0]    n_rm;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign rm_in   = {i_s, {SQ_SHIFT{1'b0}}};
            assign root_in = '0;
            assign s_in    = i_s;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rm_in   = r_rm[k];
            assign root_in = r_root[k];
            assign s_in    = r_s[k];
            assign side_in = r_side[k];
            assign vld_in  = r_vld[k];
        end

        assign rem_ext = {1'b0, rm_in};
        assign trial   = (T_W'(root_in) << (B + 1)) | (T_W'(1) << (2 * B));
        assign ge      = rem_ext >= trial;
        assign n_rm    = ge ? X_W'(rem_ext - trial) : rm_in;
        assign n_root  = ge ? (root_in | (ROOT_W'(1) << B)) : root_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[k+1]   <= n_rm;
                r_root[k+1] <= n_root;
                r_s[k+1]    <= s_in;
                r_side[k+1] <= side_in;
            end
        end
    end

    assign o_s    = r_s[SQRT_STEPS];
    assign o_root = r_root[SQRT_STEPS];
    assign o_side = r_side[SQRT_STEPS];
    assign o_vld  = r_vld[SQRT_STEPS];

endmodule

>>> sv/gpf_den.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_den
// Divisor S * R from limb products: products, per-limb sums, final sum.
// ----------------------------------------------------------------------------
module gpf_den
    import gpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [S_W-1:0]    i_s,
    input  logic [ROOT_W-1:0] i_root,
    input  t_side             i_side,
    output logic [DEN_W-1:0]  o_den,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side,
    output logic              o_vld
);

    logic [SPAD_W-1:0] s_pad;
    logic [LPP_W-1:0]  n1_pp [N_SLIMB][N_RLIMB];
    logic [LPP_W-1:0]  r1_pp [N_SLIMB][N_RLIMB];
    logic [LSUM_W-1:0] n2_sum [N_RLIMB];
    logic [LSUM_W-1:0] r2_sum [N_RLIMB];
    logic [DEN_W-1:0]  n3_den;
    logic [DEN_W-1:0]  r3_den;
    logic [ROOT_W-1:0] r1_root, r2_root, r3_root;
    t_side             r1_side, r2_side, r3_side;
    logic              r1_vld, r2_vld, r3_vld;

    assign s_pad = SPAD_W'(i_s);

    always_comb begin
        for (int i = 0; i < N_SLIMB; i++) begin
            for (int j = 0; j < N_RLIMB; j++) begin
                n1_pp[i][j] = LPP_W'(s_pad[i*SLIMB_W +: SLIMB_W])
                            * LPP_W'(i_root[j*RLIMB_W +: RLIMB_W]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < N_RLIMB; j++) begin
            n2_sum[j] = '0;
            for (int i = 0; i < N_SLIMB; i++) begin
                n2_sum[j] = n2_sum[j] + (LSUM_W'(r1_pp[i][j]) << (i * SLIMB_W));
            end
        end
    end

    always_comb begin
        n3_den = '0;
        for (int j = 0; j < N_RLIMB; j++) begin
            n3_den = n3_den + (DEN_W'(r2_sum[j]) << (j * RLIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pp   <= n1_pp;
            r1_root <= i_root;
            r1_side <= i_side;
            r2_sum  <= n2_sum;
            r2_root <= r1_root;
            r2_side <= r1_side;
            r3_den  <= n3_den;
            r3_root <= r2_root;
            r3_side <= r2_side;
        end
    end

    assign o_den  = r3_den;
    assign o_root = r3_root;
    assign o_side = r3_side;
    assign o_vld  = r3_vld;

endmodule

>>> sv/gpf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_div
// Restoring dividers, one quotient bit per stage: four acceleration
// quotients m*|d|*2^92 / (S*R) and the potential quotient ma*mb*2^32 / R.
// A leading stage flags quotients that overflow the result width.
// ----------------------------------------------------------------------------
module gpf_div
    import gpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [ROOT_W-1:0] i_root,
    input  t_side             i_side,
    output t_res              o_res,
    output logic              o_vld
);

    logic [N_ACC-1:0][DEN_W-1:0] r_arem  [0:POT_STEPS];
    logic [N_ACC-1:0][ACC_W-1:0] r_aq    [0:POT_STEPS];
    logic [N_ACC-1:0]            r_aovf  [0:POT_STEPS];
    logic [ROOT_W-1:0]           r_prem  [0:POT_STEPS];
    logic [POT_W-1:0]            r_pq    [0:POT_STEPS];
    logic                        r_povf  [0:POT_STEPS];
    logic [DEN_W-1:0]            r_den   [0:POT_STEPS];
    logic [ROOT_W-1:0]           r_root  [0:POT_STEPS];
    logic [POT_SHIFT-1:0]        r_mmlo  [0:POT_STEPS];
    t_flags                      r_flags [0:POT_STEPS];
    logic                        r_vld   [0:POT_STEPS];

    logic [N_ACC-1:0][DEN_W-1:0] n0_arem;
    logic [N_ACC-1:0]            n0_aovf;
    logic [MM_W-POT_SHIFT-1:0]   pot_hi;

    assign pot_hi = i_side.mm[MM_W-1:POT_SHIFT];

    always_comb begin
        for (int a = 0; a < N_ACC; a++) begin
            n0_arem[a] = DEN_W'({i_side.prod[a], {ACC_SHIFT{1'b0}}});
            n0_aovf[a] = n0_arem[a] >= i_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arem[0]  <= n0_arem;
            r_aq[0]    <= '0;
            r_aovf[0]  <= n0_aovf;
            r_prem[0]  <= ROOT_W'(pot_hi);
            r_pq[0]    <= '0;
            r_povf[0]  <= ROOT_W'(pot_hi) >= i_root;
            r_den[0]   <= i_den;
            r_root[0]  <= i_root;
            r_mmlo[0]  <= i_side.mm[POT_SHIFT-1:0];
            r_flags[0] <= i_side.flags;
        end
    end

    for (genvar k = 0; k < POT_STEPS; k++) begin : g_step
        localparam int PB = POT_STEPS - 1 - k;

        logic [N_ACC-1:0][DEN_W-1:0] n_arem;
        logic [N_ACC-1:0][ACC_W-1:0] n_aq;
        logic                        nbit;
        logic [ROOT_W:0]             prem2;
        logic                        pge;

        if (k < ACC_STEPS) begin : g_acc
            always_comb begin
                logic [DEN_W:0] rem2;
                logic           ge;
                for (int a = 0; a < N_ACC; a++) begin
                    rem2      = {r_arem[k][a], 1'b0};
                    ge        = rem2 >= {1'b0, r_den[k]};
                    n_arem[a] = ge ? DEN_W'(rem2 - {1'b0, r_den[k]}) : DEN_W'(rem2);
                    n_aq[a]   = {r_aq[k][a][ACC_W-2:0], ge};
                end
            end
        end else begin : g_hold
            assign n_arem = r_arem[k];
            assign n_aq   = r_aq[k];
        end

        if (PB >= POT_SHIFT) begin : g_nb_hi
            assign nbit = r_mmlo[k][PB-POT_SHIFT];
        end else begin : g_nb_lo
            assign nbit = 1'b0;
        end

        assign prem2 = {r_prem[k], nbit};
        assign pge   = prem2 >= {1'b0, r_root[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_arem[k+1]  <= n_arem;
                r_aq[k+1]    <= n_aq;
                r_aovf[k+1]  <= r_aovf[k];
                r_prem[k+1]  <= pge ? ROOT_W'(prem2 - {1'b0, r_root[k]}) : ROOT_W'(prem2);
                r_pq[k+1]    <= {r_pq[k][POT_W-2:0], pge};
                r_povf[k+1]  <= r_povf[k];
                r_den[k+1]   <= r_den[k];
                r_root[k+1]  <= r_root[k];
                r_mmlo[k+1]  <= r_mmlo[k];
                r_flags[k+1] <= r_flags[k];
            end
        end
    end

    assign o_res.q_acc   = r_aq[POT_STEPS];
    assign o_res.ovf_acc = r_aovf[POT_STEPS];
    assign o_res.q_pot   = r_pq[POT_STEPS];
    assign o_res.ovf_pot = r_povf[POT_STEPS];
    assign o_res.flags   = r_flags[POT_STEPS];
    assign o_vld         = r_vld[POT_STEPS];

endmodule

>>> sv/gravity_pair_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_pair_force_top
// Newtonian pair interaction in 2D (G = 1): acceleration increments for
// both bodies and the pair potential, exact fixed point with saturation.
// ----------------------------------------------------------------------------
// Takes one body pair per clock unless stalled. Pipeline stages in order:
// input register 1, separation and products 3, square root 66 (one root
// bit per stage), S*R product 3, overflow check 1, dividers 64 (one bit of
// the 64-bit potential quotient per stage), output register 1. Throughput
// is one pair per cycle unless stalled. When the output request is held, the
// whole pipeline stalls; the input register still takes a request while empty.
// Coincident positions give zero results with the coincident flag set.
// ----------------------------------------------------------------------------
module gravity_pair_force_top
    import gpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // acc_a_x_delta, acc_a_y_delta, acc_b_x_delta, acc_b_y_delta, pair_potential
    output logic [OUT_W-1:0] o_m_tdata,
    // coincident
    output logic             o_m_tuser
);

    logic                    en;
    logic                    r_in_vld;
    logic signed [POS_W-1:0] r_pos_a_x, r_pos_a_y, r_pos_b_x, r_pos_b_y;
    logic [MASS_W-1:0]       r_mass_a, r_mass_b;

    logic [S_W-1:0]    prep_s;
    t_side             prep_side;
    logic              prep_vld;
    logic [S_W-1:0]    sqrt_s;
    logic [ROOT_W-1:0] sqrt_root;
    t_side             sqrt_side;
    logic              sqrt_vld;
    logic [DEN_W-1:0]  den_den;
    logic [ROOT_W-1:0] den_root;
    t_side             den_side;
    logic              den_vld;
    t_res              div_res;
    logic              div_vld;

    logic [N_ACC-1:0][ACC_W-1:0] n_acc;
    logic [POT_W-1:0]            n_pot;
    logic [OUT_W-1:0]            r_out_data;
    logic                        r_out_user;
    logic                        r_out_vld;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en || !r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_pos_a_x <= i_s_tdata[0*POS_W +: POS_W];
            r_pos_a_y <= i_s_tdata[1*POS_W +: POS_W];
            r_pos_b_x <= i_s_tdata[2*POS_W +: POS_W];
            r_pos_b_y <= i_s_tdata[3*POS_W +: POS_W];
            r_mass_a  <= i_s_tdata[4*POS_W +: MASS_W];
            r_mass_b  <= i_s_tdata[4*POS_W+MASS_W +: MASS_W];
        end
    end

    gpf_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (r_in_vld),
        .i_pos_a_x (r_pos_a_x),
        .i_pos_a_y (r_pos_a_y),
        .i_pos_b_x (r_pos_b_x),
        .i_pos_b_y (r_pos_b_y),
        .i_mass_a  (r_mass_a),
        .i_mass_b  (r_mass_b),
        .o_s       (prep_s),
        .o_side    (prep_side),
        .o_vld     (prep_vld)
    );

    gpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (prep_vld),
        .i_s     (prep_s),
        .i_side  (prep_side),
        .o_s     (sqrt_s),
        .o_root  (sqrt_root),
        .o_side  (sqrt_side),
        .o_vld   (sqrt_vld)
    );

    gpf_den u_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sqrt_vld),
        .i_s     (sqrt_s),
        .i_root  (sqrt_root),
        .i_side  (sqrt_side),
        .o_den   (den_den),
        .o_root  (den_root),
        .o_side  (den_side),
        .o_vld   (den_vld)
    );

    gpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (den_vld),
        .i_den   (den_den),
        .i_root  (den_root),
        .i_side  (den_side),
        .o_res   (div_res),
        .o_vld   (div_vld)
    );

    always_comb begin
        logic [ACC_W-1:0] lim;
        logic [ACC_W-1:0] val;
        for (int a = 0; a < N_ACC; a++) begin
            lim = div_res.flags.neg[a] ? ACC_NEG_MAX : ACC_POS_MAX;
            val = (div_res.ovf_acc[a] || (div_res.q_acc[a] > lim)) ? lim : div_res.q_acc[a];
            if (div_res.flags.zero) begin
                n_acc[a] = '0;
            end else begin
                n_acc[a] = div_res.flags.neg[a] ? ACC_W'(-val) : val;
            end
        end
        if (div_res.flags.zero) begin
            n_pot = '0;
        end else begin
            n_pot = div_res.ovf_pot ? '1 : div_res.q_pot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {n_pot, n_acc};
            r_out_user <= div_res.flags.zero;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

>>> test/gravity_pair_force_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_pair_force_top_tb
// Streams body pairs through the gravity pair force pipeline. Each pair
// accepted is run through an exact wide-integer force and potential
// calculation. Each result is checked field by field, in order, against it.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module gravity_pair_force_top_tb;
    import gpf_pkg::*;

    typedef logic [255:0] wide_t;

    typedef struct {
        logic [ACC_W-1:0] acc [N_ACC];
        logic [POT_W-1:0] pot;
        logic             coinc;
    } pair_force_t;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic             o_m_tuser;

    gravity_pair_force_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic wide_t isqrt(wide_t x);
        wide_t root, t;
        root = '0;
        for (int b = ROOT_W; b >= 0; b--) begin
            t = root | (wide_t'(1) << b);
            if (t * t <= x)
                root = t;
        end
        return root;
    endfunction

    // m*|d|*2^92/(S*R), signed and saturated
    function automatic logic [ACC_W-1:0] accel(wide_t m, wide_t mag, bit neg, wide_t den);
        wide_t q;
        q = ((m * mag) << 92) / den;
        if (neg) begin
            if (q > wide_t'(ACC_NEG_MAX))
                q = wide_t'(ACC_NEG_MAX);
            return ACC_W'(-q);
        end
        if (q > wide_t'(ACC_POS_MAX))
            q = wide_t'(ACC_POS_MAX);
        return q[ACC_W-1:0];
    endfunction

    function automatic pair_force_t pair_force(logic [IN_W-1:0] req);
        pair_force_t e;
        logic signed [DIF_W-1:0] dx, dy;
        wide_t mx, my, ma, mb, s, r, den, u;
        dx = $signed(req[2*POS_W +: POS_W]) - $signed(req[0 +: POS_W]);
        dy = $signed(req[3*POS_W +: POS_W]) - $signed(req[POS_W +: POS_W]);
        ma = wide_t'(req[4*POS_W +: MASS_W]);
        mb = wide_t'(req[4*POS_W+MASS_W +: MASS_W]);
        mx = wide_t'(dx < 0 ? -dx : dx);
        my = wide_t'(dy < 0 ? -dy : dy);
        mx = mx & {{(256-DIF_W){1'b0}}, {DIF_W{1'b1}}};
        my = my & {{(256-DIF_W){1'b0}}, {DIF_W{1'b1}}};
        s = mx * mx + my * my;
        foreach (e.acc[i]) e.acc[i] = '0;
        e.pot = '0;
        e.coinc = (s == 0);
        if (s != 0) begin
            r = isqrt(s << 32);
            den = s * r;
            e.acc[0] = accel(mb, mx, dx < 0, den);
            e.acc[1] = accel(mb, my, dy < 0, den);
            e.acc[2] = accel(ma, mx, dx > 0, den);
            e.acc[3] = accel(ma, my, dy > 0, den);
            u = ((ma * mb) << 32) / r;
            e.pot = (u[255:64] != 0) ? '1 : u[63:0];
        end
        return e;
    endfunction

    class pair_force_board;
        pair_force_t pending [$];
        int          errors = 0;
        string       acc_names [N_ACC] = '{"acc_a_x_delta", "acc_a_y_delta",
                                           "acc_b_x_delta", "acc_b_y_delta"};

        function void note_request(logic [IN_W-1:0] req);
            pending.push_back(pair_force(req));
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic coinc);
            pair_force_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < N_ACC; i++)
                if (data[i*ACC_W +: ACC_W] !== e.acc[i]) begin
                    $error("%s: expected %h actual %h",
                           acc_names[i], e.acc[i], data[i*ACC_W +: ACC_W]);
                    errors++;
                end
            if (data[N_ACC*ACC_W +: POT_W] !== e.pot) begin
                $error("pair_potential: expected %h actual %h",
                       e.pot, data[N_ACC*ACC_W +: POT_W]);
                errors++;
            end
            if (coinc !== e.coinc) begin
                $error("coincident: expected %0b actual %0b", e.coinc, coinc);
                errors++;
            end
        endfunction
    endclass

    pair_force_board board = new();
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_request(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser);
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls; quiet stretches with no stalls at all
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end
            n = gap_len();
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    bit burst = 1'b0;

    task automatic send_pair(logic [POS_W-1:0] ax, ay, bx, by, logic [MASS_W-1:0] ma, mb);
        int n;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {mb, ma, by, bx, ay, ax};
        do @(posedge i_clk); while (!o_s_tready);
        n = burst ? 0 : gap_len();
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] rnd_pos();
        return POS_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [MASS_W-1:0] rnd_mass();
        return MASS_W'({$urandom(), $urandom()});
    endfunction

    localparam logic [POS_W-1:0]  PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]  PMIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [MASS_W-1:0] MMAX = '1;
    localparam logic [MASS_W-1:0] ONE  = 40'h1_00000;

    initial begin
        logic [POS_W-1:0] ax, ay, off_x, off_y;
        int k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(0, 0, 0, 0, ONE, ONE);
        send_pair(PMAX, PMIN, PMAX, PMIN, MMAX, MMAX);
        send_pair(PMIN, PMIN, PMAX, PMAX, MMAX, MMAX);
        send_pair(PMAX, PMAX, PMIN, PMIN, MMAX, MMAX);
        send_pair(PMIN, 0, PMAX, 0, ONE, ONE);
        send_pair(0, PMAX, 0, PMIN, ONE, 1);
        send_pair(0, 0, 1, 0, MMAX, MMAX);
        send_pair(0, 0, 0, -48'sd1, MMAX, 1);
        send_pair(5, 7, 4, 8, 0, MMAX);
        send_pair(5, 7, 4, 8, MMAX, 0);
        send_pair(0, 0, 48'h1_00000000, 0, ONE, ONE);
        send_pair(0, 0, 0, 48'h1_00000000, ONE, 2*ONE);
        send_pair(48'h3_00000000, 0, 0, 48'h4_00000000, ONE, ONE);
        send_pair(0, 0, 48'hFFFF_00000000, 48'h1_00000000, 3*ONE, ONE);
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(PMAX, PMAX, PMAX, PMAX, MMAX, MMAX);
        send_pair(0, 0, 48'h10, 48'h10, 1, 1);
        send_pair(0, 0, PMAX, PMAX, 1, 1);
        send_pair(1, 1, 0, 0, MMAX, ONE);
        drain();

        for (int i = 0; i < 450; i++) begin
            if (i == 225)
                drain();
            if (i % 60 == 0)
                burst = ($urandom_range(0, 2) == 0);
            ax = rnd_pos();
            ay = rnd_pos();
            k = $urandom_range(0, 99);
            if (k < 30) begin
                send_pair(ax, ay, rnd_pos(), rnd_pos(), rnd_mass(), rnd_mass());
            end else if (k < 90) begin
                off_x = rnd_pos() >>> $urandom_range(0, 47);
                off_y = rnd_pos() >>> $urandom_range(0, 47);
                send_pair(ax, ay, ax + off_x, ay + off_y,
                          rnd_mass() >> $urandom_range(0, 39),
                          rnd_mass() >> $urandom_range(0, 39));
            end else if (k < 95) begin
                send_pair(ax, ay, ax, ay, rnd_mass(), rnd_mass());
            end else begin
                send_pair(ax, ay, ax + POS_W'($urandom_range(0, 3)),
                          ay - POS_W'($urandom_range(0, 3)), MMAX, rnd_mass());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
